// ===== hdl/gers_pkg.sv =====
// ----------------------------------------------------------------------------
// gers_pkg
// shared constants and types for the guide error running statistics block
// ----------------------------------------------------------------------------
package gers_pkg;

   localparam int COUNT_BITS = 24;

   typedef enum logic [1:0] {
      MODE_GUIDE_STEP    = 2'd0,
      MODE_START_GUIDING = 2'd1,
      MODE_SETTLE_BEGIN  = 2'd2,
      MODE_SETTLE_DONE   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIFF,
      S_DIV,
      S_MEAN,
      S_MUL,
      S_ACC,
      S_RMS,
      S_RDIV,
      S_RSQ_LD,
      S_RSQ,
      S_RFIN,
      S_TSQ,
      S_TLD,
      S_TSQRT,
      S_FIN
   } state_type;

endpackage

// ===== hdl/guide_error_running_stats_top.sv =====
// ----------------------------------------------------------------------------
// guide_error_running_stats_top
// two-axis welford running deviation, peak and total rms of guiding error,
// built around a shared bit-serial divider, multiplier and square root
// ----------------------------------------------------------------------------
// an event without an update runs two 64-step divides and three 32-step square
// roots; an accumulated guide step runs two 64-step divides and two 33-step
// multiplies for the update before those; one item in flight, ready again the
// cycle after the result is loaded
// synchronous reset clears the sample count, means, deviation sums and peaks
// and turns accumulation off
module guide_error_running_stats_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,  // ra_dist[15:0], dec_dist[31:16]
   input  logic [1:0]    req_tuser,  // mode[1:0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,  // rms_ra, rms_dec, peak_ra, peak_dec,
                                     // rms_total (16 each), samples[103:80]
   output logic          rsp_tuser   // accumulating
);
   import gers_pkg::*;

   state_type state_ff, state_in;

   logic                   axis_ff;
   logic [5:0]             cnt_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic                   acc_on_ff;
   logic signed [31:0]     mean_ff [2];
   logic [63:0]            sq_ff   [2];
   logic [15:0]            peak_ff [2];
   logic signed [15:0]     x_ff    [2];
   logic [15:0]            rms_ff  [2];
   logic [32:0]            s_ff;
   logic                   sat_step_ff;

   logic [63:0]            dv_num_ff;
   logic [COUNT_BITS:0]    dv_rem_ff;
   logic [COUNT_BITS-1:0]  dv_den_ff;
   logic [65:0]            mul_p_ff;
   logic [32:0]            mul_a_ff;
   logic [32:0]            d_mag_ff;
   logic                   d_neg_ff;
   logic [63:0]            sr_op_ff;
   logic [35:0]            sr_rem_ff;
   logic [31:0]            sr_root_ff;

   logic                   rsp_valid_ff;
   logic [103:0]           rsp_data_ff;
   logic                   rsp_flag_ff;

   logic                   req_xfer;
   logic                   out_free;
   mode_type               mode;
   logic                   guide_upd;

   // serial unit step values
   logic [COUNT_BITS:0]    dv_sh;
   logic                   dv_ge;
   logic [33:0]            mul_sum;
   logic [35:0]            sr_sh;
   logic [35:0]            sr_trial;
   logic                   sr_ge;

   logic signed [33:0]     big_x;
   logic signed [33:0]     d_val;
   logic signed [33:0]     q_val;
   logic signed [33:0]     m_val;
   logic signed [33:0]     e_val;
   logic [32:0]            e_mag;
   logic [64:0]            sq_sum;
   logic [32:0]            r_rnd;
   logic [31:0]            sq16;
   logic [32:0]            h_val;
   logic [15:0]            mag_ra;
   logic [15:0]            mag_dec;

   assign req_xfer = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign mode     = mode_type'(req_tuser);
   assign guide_upd = (mode == MODE_GUIDE_STEP) && acc_on_ff && (count_ff != '1);

   always_comb begin
      dv_sh    = {dv_rem_ff[COUNT_BITS-1:0], dv_num_ff[63]};
      dv_ge    = dv_sh >= {1'b0, dv_den_ff};
      mul_sum  = {1'b0, mul_p_ff[65:33]} + (mul_p_ff[0] ? {1'b0, mul_a_ff} : 34'd0);
      sr_sh    = {sr_rem_ff[33:0], sr_op_ff[63:62]};
      sr_trial = {2'b00, sr_root_ff, 2'b01};
      sr_ge    = sr_sh >= sr_trial;
      big_x    = {{2{x_ff[axis_ff][15]}}, x_ff[axis_ff], 16'd0};
      d_val    = big_x - 34'(mean_ff[axis_ff]);
      q_val    = d_neg_ff ? -$signed({1'b0, dv_num_ff[32:0]})
                          : $signed({1'b0, dv_num_ff[32:0]});
      m_val    = 34'(mean_ff[axis_ff]) + q_val;
      e_val    = big_x - m_val;
      e_mag    = e_val[33] ? 33'(-e_val) : e_val[32:0];
      sq_sum   = {1'b0, sq_ff[axis_ff]} + {15'd0, mul_p_ff[65:16]};
      r_rnd    = {1'b0, sr_root_ff} + 33'd128;
      sq16     = rms_ff[axis_ff] * rms_ff[axis_ff];
      h_val    = {1'b0, sr_root_ff} + ((sr_rem_ff > {4'd0, sr_root_ff}) ? 33'd1 : 33'd0);
      mag_ra   = x_ff[0][15] ? 16'(-x_ff[0]) : x_ff[0];
      mag_dec  = x_ff[1][15] ? 16'(-x_ff[1]) : x_ff[1];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_xfer) state_in = guide_upd ? S_DIFF : S_RMS;
         S_DIFF:   state_in = S_DIV;
         S_DIV:    if (cnt_ff == 6'd0) state_in = S_MEAN;
         S_MEAN:   state_in = S_MUL;
         S_MUL:    if (cnt_ff == 6'd0) state_in = S_ACC;
         S_ACC:    state_in = axis_ff ? S_RMS : S_DIFF;
         S_RMS:    state_in = S_RDIV;
         S_RDIV:   if (cnt_ff == 6'd0) state_in = S_RSQ_LD;
         S_RSQ_LD: state_in = S_RSQ;
         S_RSQ:    if (cnt_ff == 6'd0) state_in = S_RFIN;
         S_RFIN:   state_in = axis_ff ? S_TSQ : S_RMS;
         S_TSQ:    if (axis_ff) state_in = S_TLD;
         S_TLD:    state_in = S_TSQRT;
         S_TSQRT:  if (cnt_ff == 6'd0) state_in = S_FIN;
         S_FIN:    if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = rsp_data_ff;
      rsp_tuser  = rsp_flag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= 1'b0;
         cnt_ff       <= 6'd0;
         count_ff     <= '0;
         acc_on_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            mean_ff[i] <= '0;
            sq_ff[i]   <= '0;
            peak_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_tready && state_ff != S_FIN) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               axis_ff <= 1'b0;
               if (req_xfer) begin
                  x_ff[0] <= req_tdata[15:0];
                  x_ff[1] <= req_tdata[31:16];
                  if (mode == MODE_START_GUIDING || mode == MODE_SETTLE_DONE) begin
                     count_ff  <= '0;
                     acc_on_ff <= 1'b1;
                     for (int i = 0; i < 2; i++) begin
                        mean_ff[i] <= '0;
                        sq_ff[i]   <= '0;
                        peak_ff[i] <= '0;
                     end
                  end else if (mode == MODE_SETTLE_BEGIN) begin
                     acc_on_ff <= 1'b0;
                  end else if (guide_upd) begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            S_DIFF: begin
               d_neg_ff  <= d_val[33];
               d_mag_ff  <= d_val[33] ? 33'(-d_val) : d_val[32:0];
               dv_num_ff <= d_val[33] ? 64'(-d_val) : {31'd0, d_val[32:0]};
               dv_rem_ff <= '0;
               dv_den_ff <= count_ff;
               cnt_ff    <= 6'd63;
            end
            S_DIV, S_RDIV: begin
               dv_rem_ff <= dv_ge ? dv_sh - {1'b0, dv_den_ff} : dv_sh;
               dv_num_ff <= {dv_num_ff[62:0], dv_ge};
               cnt_ff    <= cnt_ff - 6'd1;
            end
            S_MEAN: begin
               mean_ff[axis_ff] <= m_val[31:0];
               mul_a_ff <= d_mag_ff;
               mul_p_ff <= {33'd0, e_mag};
               cnt_ff   <= 6'd32;
            end
            S_MUL: begin
               mul_p_ff <= {mul_sum, mul_p_ff[32:1]};
               cnt_ff   <= cnt_ff - 6'd1;
            end
            S_ACC: begin
               sq_ff[axis_ff] <= sq_sum[64] ? '1 : sq_sum[63:0];
               axis_ff <= ~axis_ff;
            end
            S_RMS: begin
               dv_num_ff <= sq_ff[axis_ff];
               dv_rem_ff <= '0;
               dv_den_ff <= count_ff;
               cnt_ff    <= 6'd63;
            end
            S_RSQ_LD: begin
               sr_op_ff   <= dv_num_ff;
               sr_rem_ff  <= '0;
               sr_root_ff <= '0;
               cnt_ff     <= 6'd31;
            end
            S_RSQ, S_TSQRT: begin
               sr_op_ff   <= {sr_op_ff[61:0], 2'b00};
               sr_rem_ff  <= sr_ge ? sr_sh - sr_trial : sr_sh;
               sr_root_ff <= {sr_root_ff[30:0], sr_ge};
               cnt_ff     <= cnt_ff - 6'd1;
            end
            S_RFIN: begin
               if (count_ff == '0)
                  rms_ff[axis_ff] <= '0;
               else
                  rms_ff[axis_ff] <= (|r_rnd[32:24]) ? 16'hffff : r_rnd[23:8];
               axis_ff <= ~axis_ff;
            end
            S_TSQ: begin
               s_ff    <= (axis_ff ? s_ff : 33'd0) + {1'b0, sq16};
               axis_ff <= ~axis_ff;
            end
            S_TLD: begin
               sr_op_ff   <= {31'd0, s_ff};
               sr_rem_ff  <= '0;
               sr_root_ff <= '0;
               cnt_ff     <= 6'd31;
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_flag_ff  <= acc_on_ff;
                  rsp_data_ff  <= {count_ff,
                                   (|h_val[32:16]) ? 16'hffff : h_val[15:0],
                                   peak_ff[1], peak_ff[0], rms_ff[1], rms_ff[0]};
               end
            end
            default: ;
         endcase
         // peaks follow every accepted guide step while accumulating,
         // also when the count is saturated
         if ((state_ff == S_DIFF && !axis_ff) || sat_step_ff) begin
            if (mag_ra > peak_ff[0])  peak_ff[0] <= mag_ra;
            if (mag_dec > peak_ff[1]) peak_ff[1] <= mag_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_step_ff <= 1'b0;
      end else begin
         sat_step_ff <= req_xfer && (mode == MODE_GUIDE_STEP) && acc_on_ff
                        && (count_ff == '1);
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff != S_IDLE)
      else $error("block still idle after an input transfer");

   a_empty_sums: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> sq_ff[0] == '0 && sq_ff[1] == '0)
      else $error("deviation sum non-zero with no samples");

   a_zero_rms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[103:80] == '0 |-> rsp_data_ff[31:0] == '0)
      else $error("deviation reported with no samples");

endmodule

// ===== tb/sv/guide_error_running_stats_checker.sv =====
// ----------------------------------------------------------------------------
// guide_error_running_stats_checker
// watches both streams of the guide error statistics block, predicts every
// result from the accepted events and compares it field by field
// ----------------------------------------------------------------------------
module guide_error_running_stats_checker
   import gers_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [31:0]   req_tdata,
   input  logic [1:0]    req_tuser,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [103:0]  rsp_tdata,
   input  logic          rsp_tuser,
   output int            fail_count,
   output int            pending,
   output int            stats_seen
);

   typedef struct packed {
      logic [15:0] rms_ra;
      logic [15:0] rms_dec;
      logic [15:0] peak_ra;
      logic [15:0] dec_peak;
      logic [15:0] rms_total;
      logic [23:0] samples;
      logic        accumulating;
   } stats_type;

   stats_type   stats_q[$];
   logic [31:0] count_r;
   logic        acc_on;
   logic signed [31:0] mean_r [2];
   logic [63:0] sq_r [2];
   logic [15:0] peak_r [2];

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] axis_dev(input logic [63:0] sq);
      logic [63:0] r;
      if (count_r == 0) return 0;
      r = (int_sqrt(sq / count_r) + 128) >> 8;
      return (r > 65535) ? 65535 : r;
   endfunction

   task automatic welford_add(input int ax, input logic signed [15:0] x);
      logic signed [63:0] big, d, m, e;
      logic [63:0] ad, ae, inc;
      big = 64'(x) * 65536;
      d = big - 64'(mean_r[ax]);
      m = 64'(mean_r[ax]) + d / $signed({32'd0, count_r});
      mean_r[ax] = m[31:0];
      e = big - m;
      ad = d < 0 ? -d : d;
      ae = e < 0 ? -e : e;
      inc = (ad * ae) >> 16;
      if (sq_r[ax] > 64'hFFFF_FFFF_FFFF_FFFF - inc) sq_r[ax] = '1;
      else sq_r[ax] = sq_r[ax] + inc;
   endtask

   task automatic predict_event(input mode_type mode, input logic [31:0] data);
      logic signed [15:0] x [2];
      logic [15:0] mag;
      logic [63:0] rr, rd, s, h;
      stats_type st;
      x[0] = data[15:0];
      x[1] = data[31:16];
      case (mode)
         MODE_START_GUIDING, MODE_SETTLE_DONE: begin
            count_r = 0;
            acc_on = 1;
            for (int a = 0; a < 2; a++) begin
               mean_r[a] = 0;
               sq_r[a] = 0;
               peak_r[a] = 0;
            end
         end
         MODE_SETTLE_BEGIN: acc_on = 0;
         default: begin
            if (acc_on) begin
               for (int a = 0; a < 2; a++) begin
                  mag = x[a] < 0 ? 16'(-32'(x[a])) : x[a];
                  if (mag > peak_r[a]) peak_r[a] = mag;
               end
               if (count_r < (32'd1 << COUNT_BITS) - 1) begin
                  count_r = count_r + 1;
                  welford_add(0, x[0]);
                  welford_add(1, x[1]);
               end
            end
         end
      endcase
      rr = axis_dev(sq_r[0]);
      rd = axis_dev(sq_r[1]);
      s = rr * rr + rd * rd;
      h = int_sqrt(s);
      if (s > h * h + h) h = h + 1;
      if (h > 65535) h = 65535;
      st.rms_ra = rr[15:0];
      st.rms_dec = rd[15:0];
      st.peak_ra = peak_r[0];
      st.dec_peak = peak_r[1];
      st.rms_total = h[15:0];
      st.samples = count_r > 32'hFF_FFFF ? 24'hFF_FFFF : count_r[23:0];
      st.accumulating = acc_on;
      stats_q = {stats_q, st};
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      stats_type e;
      if (reset) begin
         count_r = 0;
         acc_on = 0;
         for (int a = 0; a < 2; a++) begin
            mean_r[a] = 0;
            sq_r[a] = 0;
            peak_r[a] = 0;
         end
         stats_q.delete();
         fail_count = 0;
         stats_seen = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            stats_seen++;
            if (stats_q.size() == 0) begin
               $error("rsp transfer with no result expected");
               fail_count++;
            end else begin
               e = stats_q[0];
               stats_q.delete(0);
               check_field("rms_ra", 32'(e.rms_ra), 32'(rsp_tdata[15:0]));
               check_field("rms_dec", 32'(e.rms_dec), 32'(rsp_tdata[31:16]));
               check_field("peak_ra", 32'(e.peak_ra), 32'(rsp_tdata[47:32]));
               check_field("dec_peak", 32'(e.dec_peak), 32'(rsp_tdata[63:48]));
               check_field("rms_total", 32'(e.rms_total), 32'(rsp_tdata[79:64]));
               check_field("samples", 32'(e.samples), 32'(rsp_tdata[103:80]));
               check_field("accumulating", 32'(e.accumulating), 32'(rsp_tuser));
            end
         end
         if (req_tvalid && req_tready) predict_event(mode_type'(req_tuser), req_tdata);
      end
      pending = stats_q.size();
   end

endmodule

// ===== tb/sv/guide_error_running_stats_top_test.sv =====
// ----------------------------------------------------------------------------
// guide_error_running_stats_top_test
// drives guiding events into the statistics block under varied stream
// pressure and reports the verdict from the checker's failure and pending counts
// ----------------------------------------------------------------------------
module guide_error_running_stats_top_test;
   import gers_pkg::*;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [31:0]   req_tdata = 0;
   logic [1:0]    req_tuser = 0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [103:0]  rsp_tdata;
   logic          rsp_tuser;
   int            fail_count;
   int            pending;
   int            stats_seen;
   int            send_idle = 0;
   int            recv_stall = 0;
   int            sent = 0;

   always #1 clock = ~clock;

   guide_error_running_stats_top dut (.*);

   guide_error_running_stats_checker checker_i (.*);

   always @(negedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   task automatic send_event(input mode_type mode, input logic [15:0] ra,
                             input logic [15:0] dec);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) @(negedge clock);
      req_tvalid <= 1;
      req_tuser <= mode;
      req_tdata <= {dec, ra};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   function automatic logic [15:0] rand_dist();
      case ($urandom_range(5))
         0: return 16'($urandom);
         1: return 16'h8000;
         2: return 16'h7FFF;
         default: return 16'($signed($urandom_range(1024)) - 512);
      endcase
   endfunction

   task automatic random_events(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 6)
            send_event(mode_type'(2'($urandom_range(3))), 16'($urandom),
                       16'($urandom));
         else
            send_event(MODE_GUIDE_STEP, rand_dist(), rand_dist());
      end
   endtask

   initial begin
      #400000000;
      $display("guide_error_running_stats_top_test failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: steps while off, clears, extremes, settle pause
      send_event(MODE_GUIDE_STEP, 16'h1234, 16'h8000);
      send_event(MODE_SETTLE_BEGIN, 16'd0, 16'd0);
      send_event(MODE_START_GUIDING, 16'd0, 16'd0);
      send_event(MODE_GUIDE_STEP, 16'h8000, 16'h7FFF);
      send_event(MODE_GUIDE_STEP, 16'h7FFF, 16'h8000);
      send_event(MODE_GUIDE_STEP, 16'h0000, 16'hFFFF);
      send_event(MODE_GUIDE_STEP, 16'h0001, 16'h0000);
      send_event(MODE_SETTLE_BEGIN, 16'd0, 16'd0);
      send_event(MODE_GUIDE_STEP, 16'h4000, 16'h4000);
      send_event(MODE_SETTLE_DONE, 16'hFFFF, 16'hFFFF);
      send_event(MODE_GUIDE_STEP, 16'h0100, 16'hFF00);
      send_event(MODE_SETTLE_DONE, 16'd0, 16'd0);
      send_event(MODE_START_GUIDING, 16'd0, 16'd0);
      send_event(MODE_GUIDE_STEP, 16'hFFFF, 16'h0001);
      send_event(MODE_GUIDE_STEP, 16'h5555, 16'hAAAA);
      // random phases with different stream pressure
      random_events(300);
      wait (pending == 0);
      send_idle = 88;
      random_events(200);
      send_idle = 0;
      recv_stall = 88;
      random_events(250);
      send_idle = 30;
      recv_stall = 30;
      random_events(285);
      @(negedge clock);
      wait (pending == 0);
      repeat (400) @(posedge clock);
      $display("covered %0d events and %0d results over idle and stall phases",
               sent, stats_seen);
      if (fail_count == 0 && pending == 0)
         $display("guide_error_running_stats_top_test passed");
      else
         $display("guide_error_running_stats_top_test failed");
      $finish;
   end

endmodule
